### rtl/ksel_pkg.sv
// ksel_pkg: shared types and constants for the streaming k-th smallest selector.
// No dependencies; used by ksel_ram, ksel_seq and the top level.
`default_nettype none

package ksel_pkg;

  localparam int unsigned MaxRank = 64;
  localparam int unsigned DataW   = 32;
  localparam int unsigned AddrW   = $clog2(MaxRank);
  localparam int unsigned CntW    = $clog2(MaxRank + 1);
  localparam int unsigned RankW   = 7;

  typedef logic [DataW-1:0] data_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [RankW-1:0] rank_t;

  // Sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StChkCmp,
    StInsRd,
    StInsCmp,
    StOutRd,
    StOutLd
  } seq_state_e;

  // Store access request from the sequencer
  typedef struct packed {
    logic  re;
    addr_t raddr;
    logic  we;
    addr_t waddr;
    data_t wdata;
  } ram_req_t;

endpackage

`default_nettype wire

### rtl/ksel_ram.sv
// ksel_ram: sorted value store, one write and one read port, registered read data.
// Depends on ksel_pkg.
`default_nettype none

module ksel_ram (
  input  wire logic              clk_i,
  input  wire ksel_pkg::ram_req_t req_i,
  output ksel_pkg::data_t        rd_data_o
);

  ksel_pkg::data_t mem [ksel_pkg::MaxRank];
  ksel_pkg::data_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

### rtl/ksel_seq.sv
// ksel_seq: insertion sequencer with the shared signed comparator.
// Depends on ksel_pkg; drives ksel_ram.
`default_nettype none

module ksel_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ksel_pkg::data_t   sample_i,
  input  wire logic              last_i,
  input  wire ksel_pkg::cnt_t    rank_i,
  output ksel_pkg::ram_req_t     ram_req_o,
  input  wire ksel_pkg::data_t   rd_data_i,
  output logic                   res_load_o,
  output ksel_pkg::data_t        res_value_o,
  output logic                   res_short_o,
  input  wire logic              res_free_i
);

  ksel_pkg::seq_state_e state_q, state_d;
  ksel_pkg::data_t      v_q, v_d;
  logic                 last_q, last_d;
  ksel_pkg::addr_t      idx_q, idx_d;
  ksel_pkg::cnt_t       count_q, count_d;

  ksel_pkg::cnt_t       cnt_cut;
  ksel_pkg::cnt_t       out_pos;
  ksel_pkg::cnt_t       k_top;
  logic                 stored_gt;
  ksel_pkg::seq_state_e post_st;

  // shared unit: stored entry strictly greater than the new sample
  assign stored_gt = $signed(rd_data_i) > $signed(v_q);

  assign cnt_cut = (count_q > rank_i) ? rank_i : count_q;
  assign k_top   = rank_i - ksel_pkg::cnt_t'(1);
  assign out_pos = count_q - ksel_pkg::cnt_t'(1);
  assign post_st = last_q ? ksel_pkg::StOutRd : ksel_pkg::StIdle;

  assign in_stall_o  = (state_q != ksel_pkg::StIdle);
  assign res_value_o = rd_data_i;
  assign res_short_o = (count_q < rank_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ksel_pkg::StIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    last_q <= last_d;
    idx_q  <= idx_d;
  end

  always_comb begin
    state_d    = state_q;
    v_d        = v_q;
    last_d     = last_q;
    idx_d      = idx_q;
    count_d    = count_q;
    ram_req_o  = '0;
    res_load_o = 1'b0;

    unique case (state_q)
      ksel_pkg::StIdle: begin
        if (in_valid_i) begin
          v_d    = sample_i;
          last_d = last_i;
          if (cnt_cut < rank_i) begin
            count_d = cnt_cut + ksel_pkg::cnt_t'(1);
            idx_d   = cnt_cut[ksel_pkg::AddrW-1:0];
            state_d = ksel_pkg::StInsRd;
          end else begin
            // store full: fetch the largest kept value
            count_d         = cnt_cut;
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = k_top[ksel_pkg::AddrW-1:0];
            state_d         = ksel_pkg::StChkCmp;
          end
        end
      end

      ksel_pkg::StChkCmp: begin
        if (stored_gt) begin
          // drop the largest, insert from its slot down
          idx_d   = k_top[ksel_pkg::AddrW-1:0];
          state_d = ksel_pkg::StInsRd;
        end else begin
          state_d = post_st;
        end
      end

      ksel_pkg::StInsRd: begin
        if (idx_q == '0) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = idx_q;
          ram_req_o.wdata = v_q;
          state_d         = post_st;
        end else begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = idx_q - ksel_pkg::addr_t'(1);
          state_d         = ksel_pkg::StInsCmp;
        end
      end

      ksel_pkg::StInsCmp: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = idx_q;
        if (stored_gt) begin
          ram_req_o.wdata = rd_data_i;
          idx_d           = idx_q - ksel_pkg::addr_t'(1);
          state_d         = ksel_pkg::StInsRd;
        end else begin
          ram_req_o.wdata = v_q;
          state_d         = post_st;
        end
      end

      ksel_pkg::StOutRd: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = out_pos[ksel_pkg::AddrW-1:0];
        state_d         = ksel_pkg::StOutLd;
      end

      ksel_pkg::StOutLd: begin
        res_load_o = res_free_i;
        if (res_free_i) begin
          count_d = '0;
          state_d = ksel_pkg::StIdle;
        end
      end

      default: begin
        state_d = ksel_pkg::StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/streaming_kth_smallest_select_top.sv
// streaming_kth_smallest_select_top: k-th smallest value of each set in a sample stream.
// Depends on ksel_pkg, ksel_ram and ksel_seq.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   sample_value_i, last_of_set_i
//   out      source     out_valid_o / out_stall_i kth_value_o, short_set_o
//   cfg      sink       cfg_we_i                  cfg_wdata_i (rank_k)
//
// One transaction in at a time. A sample is accepted, compared with the top
// entry when the store is full (where it ends if it is not smaller), then takes
// a read and a compare-and-write per entry it moves past, and lands either by a
// direct write (bottom slot) or by a read, compare and write.
// The last sample of a set then reads the top entry into the output register once
// that is free. Reset empties the store through its count; no clearing pass.
// The output register lets the next set start while a result waits on out_stall_i.
`default_nettype none

module streaming_kth_smallest_select_top (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [31:0]             sample_value_i,
  input  wire logic                    last_of_set_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [31:0]                  kth_value_o,
  output logic                         short_set_o,
  input  wire logic                    cfg_we_i,
  input  wire ksel_pkg::rank_t         cfg_wdata_i
);

  ksel_pkg::rank_t    rank_q;
  ksel_pkg::cnt_t     rank_eff;
  ksel_pkg::ram_req_t ram_req;
  ksel_pkg::data_t    rd_data;
  logic               res_load;
  ksel_pkg::data_t    res_value;
  logic               res_short;
  logic               res_free;

  logic               out_valid_q;
  ksel_pkg::data_t    kth_q;
  logic               short_q;

  // rank register, reset to one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= ksel_pkg::rank_t'(1);
    end else if (cfg_we_i) begin
      rank_q <= cfg_wdata_i;
    end
  end

  // zero counts as one, above the store depth saturates
  always_comb begin
    if (rank_q == '0) begin
      rank_eff = ksel_pkg::cnt_t'(1);
    end else if (rank_q > ksel_pkg::rank_t'(ksel_pkg::MaxRank)) begin
      rank_eff = ksel_pkg::cnt_t'(ksel_pkg::MaxRank);
    end else begin
      rank_eff = ksel_pkg::cnt_t'(rank_q);
    end
  end

  ksel_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_value_i),
    .last_i     (last_of_set_i),
    .rank_i     (rank_eff),
    .ram_req_o  (ram_req),
    .rd_data_i  (rd_data),
    .res_load_o (res_load),
    .res_value_o(res_value),
    .res_short_o(res_short),
    .res_free_i (res_free)
  );

  ksel_ram u_ram (
    .clk_i    (clk_i),
    .req_i    (ram_req),
    .rd_data_o(rd_data)
  );

  // output register: free when empty or being taken this cycle
  assign res_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      kth_q   <= res_value;
      short_q <= res_short;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kth_value_o = kth_q;
  assign short_set_o = short_q;

endmodule

`default_nettype wire
